FILE: rtl/fuzzy_fan_speed_controller_unit_assert.svh
// assertion macros shared by the controller rtl
`ifndef FUZZY_FAN_SPEED_CONTROLLER_UNIT_ASSERT_SVH
`define FUZZY_FAN_SPEED_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define FFSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ffsc_pkg.sv
`timescale 1ns / 1ps

package ffsc_pkg;

    // field widths
    localparam int TEMP_W  = 11;
    localparam int DUTY_W  = 8;
    localparam int MU_W    = 17;
    localparam int K_W     = 7;
    localparam int REC_W   = 25;
    localparam int PROD_W  = 32;
    localparam int NUM_W   = 27;
    localparam int DEN_W   = 19;
    localparam int NUM_SETS = 3;
    localparam int QUO_W   = DUTY_W;

    // reciprocal scale: exact floor((k << 16) / d) for k << 16 below 2**23 and d up to 128
    localparam int REC_SHIFT = 30;
    localparam int MU_LSB    = REC_SHIFT - 16;

    localparam logic [MU_W-1:0] ONE_Q16 = MU_W'(65536);

    // set corners in tenths of a degree: low, medium, high
    localparam int SET_A [NUM_SETS] = '{100, 220, 340};
    localparam int SET_B [NUM_SETS] = '{150, 300, 400};
    localparam int SET_C [NUM_SETS] = '{200, 300, 450};
    localparam int SET_D [NUM_SETS] = '{250, 380, 500};

    // rounded-up reciprocals of the ramp widths
    localparam int RECIP_50 = (2**REC_SHIFT + 50 - 1) / 50;
    localparam int RECIP_60 = (2**REC_SHIFT + 60 - 1) / 60;
    localparam int RECIP_80 = (2**REC_SHIFT + 80 - 1) / 80;

    localparam int REC_RISE [NUM_SETS] = '{RECIP_50, RECIP_80, RECIP_60};
    localparam int REC_FALL [NUM_SETS] = '{RECIP_50, RECIP_80, RECIP_50};

    // register reset values
    localparam logic [DUTY_W-1:0] RESET_DRIVE_LOW     = DUTY_W'(60);
    localparam logic [DUTY_W-1:0] RESET_DRIVE_MEDIUM  = DUTY_W'(140);
    localparam logic [DUTY_W-1:0] RESET_DRIVE_HIGH    = DUTY_W'(255);
    localparam logic [DUTY_W-1:0] RESET_MINIMUM_DRIVE = DUTY_W'(60);

    // register indexes
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_DRIVE_LOW     = 2'd0;
    localparam logic [1:0] REG_DRIVE_MEDIUM  = 2'd1;
    localparam logic [1:0] REG_DRIVE_HIGH    = 2'd2;
    localparam logic [1:0] REG_MINIMUM_DRIVE = 2'd3;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     sample_valid;
    } ffsc_in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] fan_duty;
        logic              any_set_fired;
    } ffsc_out_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_low;
        logic [DUTY_W-1:0] drive_medium;
        logic [DUTY_W-1:0] drive_high;
        logic [DUTY_W-1:0] minimum_drive;
    } ffsc_cfg_t;

endpackage

FILE: rtl/ffsc_cfg.sv
`timescale 1ns / 1ps

module ffsc_cfg
    import ffsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ffsc_cfg_t         cfg
);

    ffsc_cfg_t cfg_reg;
    ffsc_cfg_t cfg_next;
    logic      wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_DRIVE_LOW:     cfg_next.drive_low     = pwdata[DUTY_W-1:0];
                REG_DRIVE_MEDIUM:  cfg_next.drive_medium  = pwdata[DUTY_W-1:0];
                REG_DRIVE_HIGH:    cfg_next.drive_high    = pwdata[DUTY_W-1:0];
                REG_MINIMUM_DRIVE: cfg_next.minimum_drive = pwdata[DUTY_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_low     <= RESET_DRIVE_LOW;
            cfg_reg.drive_medium  <= RESET_DRIVE_MEDIUM;
            cfg_reg.drive_high    <= RESET_DRIVE_HIGH;
            cfg_reg.minimum_drive <= RESET_MINIMUM_DRIVE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_DRIVE_LOW:     prdata = 32'(cfg_reg.drive_low);
            REG_DRIVE_MEDIUM:  prdata = 32'(cfg_reg.drive_medium);
            REG_DRIVE_HIGH:    prdata = 32'(cfg_reg.drive_high);
            REG_MINIMUM_DRIVE: prdata = 32'(cfg_reg.minimum_drive);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ffsc_member.sv
`timescale 1ns / 1ps

module ffsc_member
    import ffsc_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [TEMP_W-1:0]           in_temp,
    output logic                               in_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [NUM_SETS-1:0][MU_W-1:0]      mu
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic s1_ready;
    logic s2_ready;

    // per-set region flags and ramp offset
    logic [NUM_SETS-1:0]           zero_reg;
    logic [NUM_SETS-1:0]           zero_next;
    logic [NUM_SETS-1:0]           one_reg;
    logic [NUM_SETS-1:0]           one_next;
    logic [NUM_SETS-1:0]           fall_reg;
    logic [NUM_SETS-1:0]           fall_next;
    logic [NUM_SETS-1:0][K_W-1:0]  k_reg;
    logic [NUM_SETS-1:0][K_W-1:0]  k_next;
    logic [NUM_SETS-1:0][MU_W-1:0] mu_reg;
    logic [NUM_SETS-1:0][MU_W-1:0] mu_next;

    logic signed [TEMP_W:0] x_ext;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    assign x_ext = {in_temp[TEMP_W-1], in_temp};

    for (genvar i = 0; i < NUM_SETS; i++)
    begin : g_set
        localparam logic signed [TEMP_W:0] CA = (TEMP_W+1)'(SET_A[i]);
        localparam logic signed [TEMP_W:0] CB = (TEMP_W+1)'(SET_B[i]);
        localparam logic signed [TEMP_W:0] CC = (TEMP_W+1)'(SET_C[i]);
        localparam logic signed [TEMP_W:0] CD = (TEMP_W+1)'(SET_D[i]);
        localparam logic [REC_W-1:0] RR = REC_W'(REC_RISE[i]);
        localparam logic [REC_W-1:0] RF = REC_W'(REC_FALL[i]);

        logic signed [TEMP_W:0] diff;
        logic [REC_W-1:0]       rec_sel;
        logic [PROD_W-1:0]      prod;

        // stage 1: region of the trapezoid and distance from the outer corner
        always_comb
        begin
            zero_next[i] = (x_ext <= CA) || (x_ext >= CD);
            one_next[i]  = (x_ext >= CB) && (x_ext <= CC);
            fall_next[i] = (x_ext > CC);
            diff         = fall_next[i] ? (CD - x_ext) : (x_ext - CA);
            k_next[i]    = diff[K_W-1:0];
        end

        // stage 2: ramp value by reciprocal multiply
        always_comb
        begin
            rec_sel = fall_reg[i] ? RF : RR;
            prod    = PROD_W'(k_reg[i]) * PROD_W'(rec_sel);
            if (zero_reg[i])
            begin
                mu_next[i] = '0;
            end
            else if (one_reg[i])
            begin
                mu_next[i] = ONE_Q16;
            end
            else
            begin
                mu_next[i] = {1'b0, prod[MU_LSB+15:MU_LSB]};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            zero_reg <= zero_next;
            one_reg  <= one_next;
            fall_reg <= fall_next;
            k_reg    <= k_next;
        end
        if (s2_ready)
        begin
            mu_reg <= mu_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign mu        = mu_reg;

endmodule

FILE: rtl/ffsc_wavg.sv
`timescale 1ns / 1ps

module ffsc_wavg
    import ffsc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [NUM_SETS-1:0][MU_W-1:0] mu,
    input  ffsc_cfg_t                     cfg,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [NUM_W-1:0]              num,
    output logic [DEN_W-1:0]              den
);

    logic             valid_reg;
    logic             valid_next;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // weighted sum and sum of weights
    always_comb
    begin
        num_next = NUM_W'(mu[0]) * NUM_W'(cfg.drive_low)
                 + NUM_W'(mu[1]) * NUM_W'(cfg.drive_medium)
                 + NUM_W'(mu[2]) * NUM_W'(cfg.drive_high);
        den_next = DEN_W'(mu[0]) + DEN_W'(mu[1]) + DEN_W'(mu[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

FILE: rtl/ffsc_div.sv
`timescale 1ns / 1ps
`include "fuzzy_fan_speed_controller_unit_assert.svh"

module ffsc_div
    import ffsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QUO_W-1:0]  quo,
    output logic              fired
);

    // one quotient bit per stage, most significant first
    logic              val_reg [QUO_W];
    logic              val_next [QUO_W];
    logic [NUM_W-1:0]  rem_reg [QUO_W];
    logic [NUM_W-1:0]  rem_next [QUO_W];
    logic [DEN_W-1:0]  den_reg [QUO_W];
    logic [QUO_W-1:0]  q_reg [QUO_W];
    logic [QUO_W-1:0]  q_next [QUO_W];
    logic              rdy [QUO_W+1];

    logic              src_val [QUO_W];
    logic [NUM_W-1:0]  src_rem [QUO_W];
    logic [DEN_W-1:0]  src_den [QUO_W];
    logic [QUO_W-1:0]  src_q [QUO_W];

    assign rdy[QUO_W] = out_ready;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - j;

        logic [NUM_W-1:0] shifted;
        logic [NUM_W-1:0] trial;
        logic             take;

        if (j == 0)
        begin : g_first
            assign src_val[j] = in_valid;
            assign src_rem[j] = num;
            assign src_den[j] = den;
            assign src_q[j]   = '0;
        end
        else
        begin : g_rest
            assign src_val[j] = val_reg[j-1];
            assign src_rem[j] = rem_reg[j-1];
            assign src_den[j] = den_reg[j-1];
            assign src_q[j]   = q_reg[j-1];
        end

        assign rdy[j] = !val_reg[j] || rdy[j+1];

        // restoring step
        always_comb
        begin
            shifted     = NUM_W'(src_den[j]) << BIT;
            trial       = src_rem[j] - shifted;
            take        = (src_rem[j] >= shifted);
            rem_next[j] = take ? trial : src_rem[j];
            q_next[j]   = src_q[j];
            q_next[j][BIT] = take;
            val_next[j] = rdy[j] ? src_val[j] : val_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[j] <= 1'b0;
            end
            else
            begin
                val_reg[j] <= val_next[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= src_den[j];
                q_reg[j]   <= q_next[j];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = val_reg[QUO_W-1];
    assign quo       = q_reg[QUO_W-1];
    assign fired     = (den_reg[QUO_W-1] != '0);

    // remainder after the last step is below the divisor
    `FFSC_ASSERT_NOW(a_rem_below_den,
        val_reg[QUO_W-1] && (den_reg[QUO_W-1] != '0),
        rem_reg[QUO_W-1] < NUM_W'(den_reg[QUO_W-1]),
        "division remainder not below divisor")
    // the first step leaves less than half the full range
    `FFSC_ASSERT_NOW(a_first_step,
        val_reg[0] && (den_reg[0] != '0),
        rem_reg[0] < (NUM_W'(den_reg[0]) << (QUO_W - 1)),
        "quotient overflowed its width")
    // no weights means no weighted sum
    `FFSC_ASSERT_NOW(a_zero_den,
        val_reg[QUO_W-1] && (den_reg[QUO_W-1] == '0),
        rem_reg[QUO_W-1] == '0,
        "weighted sum without weights")

endmodule

FILE: rtl/fuzzy_fan_speed_controller_unit.sv
`timescale 1ns / 1ps
`include "fuzzy_fan_speed_controller_unit_assert.svh"
//  channel   handshake               payload
//  input     in_valid / in_stall     in_data  (temperature, sample_valid)
//  output    out_valid / out_stall   out_data (fan_duty, any_set_fired)
//  config    psel / penable / pready paddr, pwdata, prdata
//
//  one request per cycle while the output is not held; a result passes through the pipeline:
//  two membership stages, one weighted-sum stage, eight
//  restoring divide stages (one quotient bit each) and the output register
//  reset clears every valid bit and loads the drive registers with their defaults
//  a held output fills empty stages behind it; in_stall rises only when all are full
//  requests with sample_valid low are taken and give no result

module fuzzy_fan_speed_controller_unit
    import ffsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ffsc_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ffsc_out_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    ffsc_cfg_t                     cfg;
    logic                          mem_in_ready;
    logic                          mem_valid;
    logic [NUM_SETS-1:0][MU_W-1:0] mu;
    logic                          avg_ready;
    logic                          avg_valid;
    logic [NUM_W-1:0]              num;
    logic [DEN_W-1:0]              den;
    logic                          div_ready;
    logic                          div_valid;
    logic [QUO_W-1:0]              quo;
    logic                          fired;
    logic                          out_ready;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ffsc_out_t                     out_data_reg;
    ffsc_out_t                     out_data_next;

    ffsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // invalid samples are taken and dropped here
    ffsc_member u_member (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && in_data.sample_valid),
        .in_temp   (in_data.temperature),
        .in_ready  (mem_in_ready),
        .out_valid (mem_valid),
        .out_ready (avg_ready),
        .mu        (mu)
    );

    ffsc_wavg u_wavg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mem_valid),
        .mu        (mu),
        .cfg       (cfg),
        .in_ready  (avg_ready),
        .out_valid (avg_valid),
        .out_ready (div_ready),
        .num       (num),
        .den       (den)
    );

    ffsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (avg_valid),
        .num       (num),
        .den       (den),
        .in_ready  (div_ready),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .quo       (quo),
        .fired     (fired)
    );

    assign in_stall = !mem_in_ready;

    // output stage: minimum drive raise and result register
    assign out_ready      = !out_valid_reg || !out_stall;
    assign out_valid_next = out_ready ? div_valid : out_valid_reg;

    always_comb
    begin
        out_data_next.any_set_fired = fired;
        if (!fired)
        begin
            out_data_next.fan_duty = '0;
        end
        else if ((quo != '0) && (quo < cfg.minimum_drive))
        begin
            out_data_next.fan_duty = cfg.minimum_drive;
        end
        else
        begin
            out_data_next.fan_duty = quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no set fired means the fan is off
    `FFSC_ASSERT_NOW(a_off_when_idle,
        out_valid_reg && !out_data_reg.any_set_fired,
        out_data_reg.fan_duty == '0,
        "duty nonzero with no set fired")
    // a running fan never sits below the minimum drive
    `FFSC_ASSERT_NOW(a_min_drive,
        out_valid_reg && out_data_reg.any_set_fired && (out_data_reg.fan_duty != '0),
        out_data_reg.fan_duty >= cfg.minimum_drive,
        "duty below minimum drive")
    // input back-pressure only when the output is held
    `FFSC_ASSERT_NOW(a_stall_source,
        in_stall,
        out_valid_reg && out_stall,
        "input stalled with room in the pipeline")

endmodule
